[src/dics_pkg.sv]
// Shared types and constants for the discrete inverse-CDF sampler.
// Depends on nothing; every other file imports it.
`timescale 1ns / 1ps

package dics_pkg;

    localparam int VALUE_W     = 32;
    localparam int WEIGHT_IN_W = 24;
    localparam int UNIFORM_W   = 32;
    localparam int CUM_W       = 32;
    localparam int PROD_W      = 64;
    localparam int INDEX_OUT_W = 8;
    localparam int STATUS_W    = 2;
    localparam int COMMAND_W   = 2;

    localparam logic [COMMAND_W-1:0] CMD_CLEAR  = 2'd0;
    localparam logic [COMMAND_W-1:0] CMD_APPEND = 2'd1;
    localparam logic [COMMAND_W-1:0] CMD_SAMPLE = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MULT,
        S_PROBE,
        S_CMP,
        S_FETCH
    } search_state_t;

    typedef struct packed {
        logic go;
    } search_req_t;

    typedef struct packed {
        logic done;
    } search_rsp_t;

endpackage

[src/dics_store.sv]
// Value and cumulative-weight memories of the sampler table.
// One write port shared by both, one registered read port each; uses dics_pkg.
`timescale 1ns / 1ps

module dics_store
    import dics_pkg::*;
#(
    parameter int DEPTH = 256,
    parameter int IDX_W = 8
)
(
    input  logic               clk,
    input  logic               wr_en,
    input  logic [IDX_W-1:0]   wr_addr,
    input  logic [VALUE_W-1:0] wr_value,
    input  logic [CUM_W-1:0]   wr_cum,
    input  logic [IDX_W-1:0]   cum_rd_addr,
    output logic [CUM_W-1:0]   cum_rd_data,
    input  logic [IDX_W-1:0]   val_rd_addr,
    output logic [VALUE_W-1:0] val_rd_data
);

    logic [VALUE_W-1:0] value_mem [DEPTH];
    logic [CUM_W-1:0]   cum_mem   [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            value_mem[wr_addr] <= wr_value;
            cum_mem[wr_addr]   <= wr_cum;
        end
        cum_rd_data <= cum_mem[cum_rd_addr];
        val_rd_data <= value_mem[val_rd_addr];
    end

endmodule

[src/dics_search.sv]
// Lower-bound search over the cumulative-weight memory for one sample.
// Drives the read ports of dics_store; uses dics_pkg.
`timescale 1ns / 1ps

module dics_search
    import dics_pkg::*;
#(
    parameter int IDX_W = 8
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  search_req_t          req,
    input  logic [UNIFORM_W-1:0] uniform_in,
    input  logic [CUM_W-1:0]     total_in,
    input  logic [IDX_W-1:0]     last_in,
    output search_rsp_t          rsp,
    output logic [IDX_W-1:0]     result_index,
    output logic [VALUE_W-1:0]   result_value,
    output logic [IDX_W-1:0]     cum_rd_addr,
    input  logic [CUM_W-1:0]     cum_rd_data,
    output logic [IDX_W-1:0]     val_rd_addr,
    input  logic [VALUE_W-1:0]   val_rd_data
);

    search_state_t        state_reg, state_next;
    logic [IDX_W-1:0]     lo_reg, lo_next;
    logic [IDX_W-1:0]     hi_reg, hi_next;
    logic [UNIFORM_W-1:0] u_reg, u_next;
    logic [CUM_W-1:0]     tot_reg, tot_next;
    logic [PROD_W-1:0]    prod_reg, prod_next;
    logic [IDX_W-1:0]     mid;
    logic                 qualifies;

    assign mid = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign qualifies = (cum_rd_data > prod_reg[PROD_W-1:CUM_W])
        || ((cum_rd_data == prod_reg[PROD_W-1:CUM_W]) && !(|prod_reg[CUM_W-1:0]));

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  state_next = req.go ? S_MULT : S_IDLE;
            S_MULT:  state_next = S_PROBE;
            S_PROBE: state_next = (lo_reg < hi_reg) ? S_CMP : S_FETCH;
            S_CMP:   state_next = S_PROBE;
            S_FETCH: state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        lo_next   = lo_reg;
        hi_next   = hi_reg;
        u_next    = u_reg;
        tot_next  = tot_reg;
        prod_next = prod_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req.go)
                begin
                    lo_next  = '0;
                    hi_next  = last_in;
                    u_next   = uniform_in;
                    tot_next = total_in;
                end
            end
            S_MULT:
            begin
                prod_next = PROD_W'(u_reg) * PROD_W'(tot_reg);
            end
            S_CMP:
            begin
                if (qualifies)
                begin
                    hi_next = mid;
                end
                else
                begin
                    lo_next = mid + IDX_W'(1);
                end
            end
            default:
            begin
                lo_next = lo_reg;
            end
        endcase
    end

    always_comb
    begin
        cum_rd_addr  = mid;
        val_rd_addr  = lo_reg;
        rsp.done     = (state_reg == S_FETCH);
        result_index = lo_reg;
        result_value = val_rd_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg   <= lo_next;
        hi_reg   <= hi_next;
        u_reg    <= u_next;
        tot_reg  <= tot_next;
        prod_reg <= prod_next;
    end

endmodule

[src/discrete_inverse_cdf_sampler.sv]
// Top level of the discrete inverse-CDF sampler: command decode, table count
// and running total, result register. Uses dics_pkg, dics_store, dics_search.
//
// Usage. A command transfer happens at a rising edge with start high and busy
// low; command, entry_value, entry_weight and uniform_word are sampled there.
// Every command gives exactly one result: done is high for one cycle with
// status, sampled_value and sampled_index valid. The receiver cannot stall.
// Clear and append results appear one cycle after the transfer and busy stays
// low, so such commands may be issued every cycle. A draw on a table of n
// entries holds busy high and makes between floor(log2(n)) and ceil(log2(n))
// binary-search probes, depending on the path of the search. Its steps are
// the registered 32x32 product, then the probes, each a read of the
// cumulative memory and a compare, then a read of the value memory, and
// last the load of the result register. Busy falls as the result appears, so
// the next command can be transferred at the edge that ends the result cycle.
// A draw on an empty table returns status empty in the cycle after the transfer.
// Reset clears the entry count, the total and the control state. The table
// memories are not cleared; entries past the count are never used by a draw.
`timescale 1ns / 1ps

module discrete_inverse_cdf_sampler
    import dics_pkg::*;
#(
    parameter int MAX_ENTRIES = 256,
    parameter int WEIGHT_BITS = 24
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [COMMAND_W-1:0]          command,
    input  logic signed [VALUE_W-1:0]     entry_value,
    input  logic [WEIGHT_IN_W-1:0]        entry_weight,
    input  logic [UNIFORM_W-1:0]          uniform_word,
    output logic                          done,
    output logic [STATUS_W-1:0]           status,
    output logic signed [VALUE_W-1:0]     sampled_value,
    output logic [INDEX_OUT_W-1:0]        sampled_index
);

    localparam int IDX_W = $clog2(MAX_ENTRIES);
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam logic [CUM_W:0] WMASK_WIDE = (CUM_W + 1)'((64'd1 << WEIGHT_BITS) - 64'd1);
    localparam logic [CUM_W-1:0] WMASK = WMASK_WIDE[CUM_W-1:0];
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ENTRIES);

    logic [CNT_W-1:0]       count_reg, count_next;
    logic [CUM_W-1:0]       total_reg, total_next;
    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic [STATUS_W-1:0]    status_reg, status_next;
    logic [VALUE_W-1:0]     value_reg, value_next;
    logic [INDEX_OUT_W-1:0] index_reg, index_next;

    logic                   accept;
    logic [CUM_W-1:0]       weight;
    logic [CUM_W:0]         sum;
    logic [CUM_W-1:0]       sum_sat;
    logic                   wr_en;
    search_req_t            req;
    search_rsp_t            rsp;
    logic [IDX_W-1:0]       last_index;
    logic [IDX_W-1:0]       result_index;
    logic [VALUE_W-1:0]     result_value;
    logic [IDX_W+INDEX_OUT_W-1:0] index_ext;
    logic [IDX_W-1:0]       cum_rd_addr;
    logic [CUM_W-1:0]       cum_rd_data;
    logic [IDX_W-1:0]       val_rd_addr;
    logic [VALUE_W-1:0]     val_rd_data;

    assign accept     = start && !busy_reg;
    assign weight     = CUM_W'(entry_weight) & WMASK;
    assign sum        = {1'b0, total_reg} + {1'b0, weight};
    assign sum_sat    = sum[CUM_W] ? '1 : sum[CUM_W-1:0];
    assign last_index = IDX_W'(count_reg - CNT_W'(1));
    assign index_ext  = {{INDEX_OUT_W{1'b0}}, result_index};

    always_comb
    begin
        count_next  = count_reg;
        total_next  = total_reg;
        busy_next   = busy_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        value_next  = value_reg;
        index_next  = index_reg;
        wr_en       = 1'b0;
        req.go      = 1'b0;
        if (accept)
        begin
            status_next = STATUS_OK;
            value_next  = '0;
            index_next  = '0;
            case (command)
                CMD_CLEAR:
                begin
                    count_next = '0;
                    total_next = '0;
                    done_next  = 1'b1;
                end
                CMD_APPEND:
                begin
                    done_next = 1'b1;
                    if (count_reg >= CNT_MAX)
                    begin
                        status_next = STATUS_FULL;
                    end
                    else
                    begin
                        wr_en      = 1'b1;
                        total_next = sum_sat;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                CMD_SAMPLE:
                begin
                    if (count_reg == '0)
                    begin
                        status_next = STATUS_EMPTY;
                        done_next   = 1'b1;
                    end
                    else
                    begin
                        req.go    = 1'b1;
                        busy_next = 1'b1;
                    end
                end
                default:
                begin
                    done_next = 1'b1;
                end
            endcase
        end
        else if (rsp.done)
        begin
            busy_next   = 1'b0;
            done_next   = 1'b1;
            status_next = STATUS_OK;
            value_next  = result_value;
            index_next  = index_ext[INDEX_OUT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            total_reg <= '0;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            total_reg <= total_next;
            busy_reg  <= busy_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        value_reg  <= value_next;
        index_reg  <= index_next;
    end

    dics_store #(
        .DEPTH (MAX_ENTRIES),
        .IDX_W (IDX_W)
    ) u_store (
        .clk         (clk),
        .wr_en       (wr_en),
        .wr_addr     (count_reg[IDX_W-1:0]),
        .wr_value    (VALUE_W'(entry_value)),
        .wr_cum      (sum_sat),
        .cum_rd_addr (cum_rd_addr),
        .cum_rd_data (cum_rd_data),
        .val_rd_addr (val_rd_addr),
        .val_rd_data (val_rd_data)
    );

    dics_search #(
        .IDX_W (IDX_W)
    ) u_search (
        .clk          (clk),
        .rst_n        (rst_n),
        .req          (req),
        .uniform_in   (uniform_word),
        .total_in     (total_reg),
        .last_in      (last_index),
        .rsp          (rsp),
        .result_index (result_index),
        .result_value (result_value),
        .cum_rd_addr  (cum_rd_addr),
        .cum_rd_data  (cum_rd_data),
        .val_rd_addr  (val_rd_addr),
        .val_rd_data  (val_rd_data)
    );

    assign busy          = busy_reg;
    assign done          = done_reg;
    assign status        = status_reg;
    assign sampled_value = signed'(value_reg);
    assign sampled_index = index_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_MAX)
        else $error("entry count exceeds table depth");

    a_draw_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && command == CMD_SAMPLE && count_reg != '0) |=> busy_reg)
        else $error("draw on a filled table did not start a search");

    a_no_done_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !(busy_reg && done_reg))
        else $error("result strobe while a search is running");

    a_error_zero_payload: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && status_reg != STATUS_OK) |-> (value_reg == '0 && index_reg == '0))
        else $error("error result carries a nonzero payload");

endmodule
